@@ design/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the four-component normalise / abs unit.
// ----------------------------------------------------------------------------
`default_nettype none
package vna_pkg;

  localparam int COMP_W = 24;
  localparam int LEN_W  = 25;
  localparam int SUM_W  = 49;
  localparam int ROOT_W = 25;
  localparam int QUO_W  = 18;
  localparam int FRAC_BITS = 16;

  typedef enum logic {
    CMD_NORMALIZE = 1'b0,
    CMD_ABS       = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               command;
    logic signed [23:0] in_x;
    logic signed [23:0] in_y;
    logic signed [23:0] in_z;
    logic signed [23:0] in_w;
  } vna_in_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic signed [23:0] out_w;
    logic        [24:0] vec_length;
    logic               zero_length;
  } vna_out_t;

  // Shared stage control: the advance enable seen by every pipeline stage.
  typedef struct packed {
    logic advance;
  } vna_ctrl_t;

endpackage
`default_nettype wire

@@ design/vna_sqrt_stage.sv @@
// ----------------------------------------------------------------------------
// vna_sqrt_stage
// One stage of a restoring square root: retires STEPS result bits per
// clock while advancing, carrying remainder, partial root and a side payload.
// ----------------------------------------------------------------------------
`default_nettype none
module vna_sqrt_stage #(
  parameter int STEPS   = 5,
  parameter int FIRST   = 24,
  parameter int SIDE_W  = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire vna_pkg::vna_ctrl_t       ctrl,
  input  wire                           valid_in,
  input  wire [vna_pkg::SUM_W-1:0]      rem_in,
  input  wire [vna_pkg::ROOT_W-1:0]     root_in,
  input  wire [SIDE_W-1:0]              side_in,
  output logic                          valid,
  output logic [vna_pkg::SUM_W-1:0]     rem,
  output logic [vna_pkg::ROOT_W-1:0]    root,
  output logic [SIDE_W-1:0]             side
);

  logic [vna_pkg::SUM_W-1:0]  rem_next;
  logic [vna_pkg::ROOT_W-1:0] root_next;

  // Classic digit recurrence: trial = (root << (k+1)) + (1 << 2k).
  always_comb begin
    logic [vna_pkg::SUM_W+1:0] trial;
    rem_next  = rem_in;
    root_next = root_in;
    for (int s = 0; s < STEPS; s++) begin
      if (FIRST - s >= 0) begin
        trial = ({{(vna_pkg::SUM_W+2-vna_pkg::ROOT_W){1'b0}}, root_next}
                 << ((FIRST - s) + 1))
                | ((vna_pkg::SUM_W+2)'(1) << (2 * (FIRST - s)));
        if ({2'b00, rem_next} >= trial) begin
          rem_next  = rem_next - trial[vna_pkg::SUM_W-1:0];
          root_next = root_next | (vna_pkg::ROOT_W'(1) << (FIRST - s));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      rem  <= rem_next;
      root <= root_next;
      side <= side_in;
    end
  end

endmodule
`default_nettype wire

@@ design/vna_div_stage.sv @@
// ----------------------------------------------------------------------------
// vna_div_stage
// Several restoring-division quotient bits per stage for the four lanes,
// all sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module vna_div_stage #(
  parameter int STEPS  = 5,
  parameter int FIRST  = 17,
  parameter int SIDE_W = 8
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire vna_pkg::vna_ctrl_t    ctrl,
  input  wire                        valid_in,
  input  wire [42:0]                 num_in  [4],
  input  wire [25:0]                 den,
  input  wire [vna_pkg::QUO_W-1:0]   quo_in  [4],
  input  wire [SIDE_W-1:0]           side_in,
  output logic                       valid,
  output logic [42:0]                num     [4],
  output logic [vna_pkg::QUO_W-1:0]  quo     [4],
  output logic [SIDE_W-1:0]          side
);

  logic [42:0]               num_next [4];
  logic [vna_pkg::QUO_W-1:0] quo_next [4];

  // Numerator < den * 2^18, so each lane's remainder stays within 43 bits.
  always_comb begin
    logic [43+vna_pkg::QUO_W:0] shifted;
    for (int l = 0; l < 4; l++) begin
      num_next[l] = num_in[l];
      quo_next[l] = quo_in[l];
      for (int s = 0; s < STEPS; s++) begin
        if (FIRST - s >= 0) begin
          shifted = {{(vna_pkg::QUO_W+1){1'b0}}, den} << (FIRST - s);
          if ({{(vna_pkg::QUO_W+1){1'b0}}, num_next[l]} >= shifted) begin
            num_next[l] = num_next[l] - shifted[42:0];
            quo_next[l] = quo_next[l] | (vna_pkg::QUO_W'(1) << (FIRST - s));
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.advance) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      num  <= num_next;
      quo  <= quo_next;
      side <= side_in;
    end
  end

endmodule
`default_nettype wire

@@ design/vec4_normalize_abs_unit.sv @@
// ----------------------------------------------------------------------------
// vec4_normalize_abs_unit
// Streaming four-component normalise / absolute-value unit, Q7.16.
// ----------------------------------------------------------------------------
// A new transaction can be accepted on every clock on which the output does
// not stall. Each vector passes through a fixed pipeline of 13 register
// stages (magnitudes, sum of squares, five square-root stages of five root
// bits, rounding, four stages of up to five quotient bits, and the output
// register, which also applies sign, saturation and the command select). The
// whole pipeline advances together whenever its last stage is empty or being
// taken downstream; a stall on the output freezes every stage, so nothing is
// lost or repeated. Command 0 gives the rounded Euclidean length and each
// component divided by it, rounded to nearest with ties away from zero; an
// all-zero vector raises zero_length with zero components. Command 1 gives
// componentwise magnitudes, the most negative value saturating to the
// largest positive one.
`default_nettype none
module vec4_normalize_abs_unit (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire vna_pkg::vna_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output vna_pkg::vna_out_t      out_data
);

  // Side payload carried alongside the arithmetic: command, signs, magnitudes.
  localparam int SIDE_W = 1 + 4 + 4 * 24;

  vna_pkg::vna_ctrl_t ctrl;
  assign ctrl.advance = !out_valid || out_ready;
  assign in_ready     = ctrl.advance;

  // ---- Stage 1: magnitudes ------------------------------------------------
  logic              s1_valid;
  logic [SIDE_W-1:0] s1_side;
  logic [23:0]       s1_mag [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      s1_mag[l] = s1_side[l*24 +: 24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctrl.advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [23:0] c [4];
    c[0] = in_data.in_x;
    c[1] = in_data.in_y;
    c[2] = in_data.in_z;
    c[3] = in_data.in_w;
    if (ctrl.advance) begin
      s1_side[SIDE_W-1] <= in_data.command;
      for (int l = 0; l < 4; l++) begin
        s1_side[96 + l] <= c[l][23];
        s1_side[l*24 +: 24] <= c[l][23] ? 24'(-c[l]) : 24'(c[l]);
      end
    end
  end

  // ---- Stage 2: sum of squares --------------------------------------------
  logic                      s2_valid;
  logic [SIDE_W-1:0]         s2_side;
  logic [vna_pkg::SUM_W-1:0] s2_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ctrl.advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      s2_side <= s1_side;
      s2_sum  <= vna_pkg::SUM_W'(48'(s1_mag[0]) * 48'(s1_mag[0]))
               + vna_pkg::SUM_W'(48'(s1_mag[1]) * 48'(s1_mag[1]))
               + vna_pkg::SUM_W'(48'(s1_mag[2]) * 48'(s1_mag[2]))
               + vna_pkg::SUM_W'(48'(s1_mag[3]) * 48'(s1_mag[3]));
    end
  end

  // ---- Stages 3..7: square root, five bits each ---------------------------
  logic                       sq_valid [6];
  logic [vna_pkg::SUM_W-1:0]  sq_rem   [6];
  logic [vna_pkg::ROOT_W-1:0] sq_root  [6];
  logic [SIDE_W-1:0]          sq_side  [6];

  assign sq_valid[0] = s2_valid;
  assign sq_rem[0]   = s2_sum;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = s2_side;

  for (genvar g = 0; g < 5; g++) begin : g_sqrt
    vna_sqrt_stage #(
      .STEPS  (5),
      .FIRST  (24 - 5 * g),
      .SIDE_W (SIDE_W)
    ) u_sqrt (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .valid_in (sq_valid[g]),
      .rem_in   (sq_rem[g]),
      .root_in  (sq_root[g]),
      .side_in  (sq_side[g]),
      .valid    (sq_valid[g+1]),
      .rem      (sq_rem[g+1]),
      .root     (sq_root[g+1]),
      .side     (sq_side[g+1])
    );
  end

  // ---- Stage 8: round the length, form numerators -------------------------
  // With remainder S - r*r, rounding up happens when the remainder exceeds r.
  logic              s8_valid;
  logic [SIDE_W-1:0] s8_side;
  logic [24:0]       s8_len;
  logic [42:0]       s8_num [4];
  logic [vna_pkg::QUO_W-1:0] zero_quo [4];
  logic [24:0]       len_next;

  assign zero_quo = '{default: '0};
  assign len_next = (sq_rem[5] > vna_pkg::SUM_W'(sq_root[5])) ? sq_root[5] + 25'd1
                                                             : sq_root[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (ctrl.advance) begin
      s8_valid <= sq_valid[5];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      s8_side <= sq_side[5];
      s8_len  <= len_next;
      for (int l = 0; l < 4; l++) begin
        s8_num[l] <= {2'b00, sq_side[5][l*24 +: 24], 17'd0} + 43'(len_next);
      end
    end
  end

  // ---- Stages 9..12: quotient, up to five bits each ----------------------
  localparam int SIDE2_W = SIDE_W + 25;
  logic                      dv_valid [5];
  logic [42:0]               dv_num   [5][4];
  logic [vna_pkg::QUO_W-1:0] dv_quo   [5][4];
  logic [SIDE2_W-1:0]        dv_side  [5];

  assign dv_valid[0] = s8_valid;
  assign dv_num[0]   = s8_num;
  assign dv_quo[0]   = zero_quo;
  assign dv_side[0]  = {s8_len, s8_side};

  for (genvar g = 0; g < 4; g++) begin : g_div
    vna_div_stage #(
      .STEPS  (5),
      .FIRST  (17 - 5 * g),
      .SIDE_W (SIDE2_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .valid_in (dv_valid[g]),
      .num_in   (dv_num[g]),
      .den      ({dv_side[g][SIDE2_W-1 -: 25], 1'b0}),
      .quo_in   (dv_quo[g]),
      .side_in  (dv_side[g]),
      .valid    (dv_valid[g+1]),
      .num      (dv_num[g+1]),
      .quo      (dv_quo[g+1]),
      .side     (dv_side[g+1])
    );
  end

  // ---- Sign, saturation and command select --------------------------------
  logic [24:0]  fin_len;
  logic         fin_cmd;
  vna_pkg::vna_out_t res_next;

  assign fin_len = dv_side[4][SIDE2_W-1 -: 25];
  assign fin_cmd = dv_side[4][SIDE_W-1];

  always_comb begin
    logic [23:0] lane [4];
    logic [23:0] mag;
    logic        neg;
    for (int l = 0; l < 4; l++) begin
      mag = dv_side[4][l*24 +: 24];
      neg = dv_side[4][96 + l];
      if (vna_pkg::cmd_t'(fin_cmd) == vna_pkg::CMD_ABS) begin
        lane[l] = mag[23] ? 24'h7FFFFF : mag;
      end else if (fin_len == '0) begin
        lane[l] = '0;
      end else begin
        // Quotient is at most 2^16, well inside the signed range.
        lane[l] = neg ? 24'(-{6'd0, dv_quo[4][l]}) : {6'd0, dv_quo[4][l]};
      end
    end
    res_next.out_x = lane[0];
    res_next.out_y = lane[1];
    res_next.out_z = lane[2];
    res_next.out_w = lane[3];
    res_next.vec_length  = (vna_pkg::cmd_t'(fin_cmd) == vna_pkg::CMD_ABS) ? '0 : fin_len;
    res_next.zero_length = (vna_pkg::cmd_t'(fin_cmd) == vna_pkg::CMD_NORMALIZE)
                           && (fin_len == '0);
  end

  // ---- Stage 13: output register ------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= dv_valid[4];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      out_data <= res_next;
    end
  end

  // ---- Assertions ---------------------------------------------------------
  a_zero_flag_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_length |-> out_data.vec_length == '0
      && out_data.out_x == '0 && out_data.out_y == '0)
    else $error("zero_length with non-zero payload");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.vec_length != '0 |->
      (out_data.out_x[23] ? -out_data.out_x : out_data.out_x) <= 24'sd65536)
    else $error("normalised component above one");

endmodule
`default_nettype wire

@@ sim/vec4_normalize_abs_checker.sv @@
// ----------------------------------------------------------------------------
// vec4_normalize_abs_checker
// Watches both channels of the normalise / abs unit, predicts each result
// from the accepted input vector and compares it field by field.
// ----------------------------------------------------------------------------
module vec4_normalize_abs_checker
  import vna_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  input  wire      in_ready,
  input  vna_in_t  in_data,
  input  wire      out_valid,
  input  wire      out_ready,
  input  vna_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  vna_out_t awaited_results[$];

  function automatic logic [23:0] clamp_comp(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic logic [63:0] isqrt_floor(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 60;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic vna_out_t predict_vector(vna_in_t v);
    vna_out_t r;
    longint comp[4];
    logic [63:0] mag[4];
    logic [63:0] sum;
    logic [63:0] root;
    logic [63:0] len;
    logic [63:0] q;
    longint sv;
    comp[0] = longint'(v.in_x);
    comp[1] = longint'(v.in_y);
    comp[2] = longint'(v.in_z);
    comp[3] = longint'(v.in_w);
    r = '0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
      sum += mag[i] * mag[i];
    end
    if (cmd_t'(v.command) == CMD_ABS) begin
      r.out_x = clamp_comp(mag[0]);
      r.out_y = clamp_comp(mag[1]);
      r.out_z = clamp_comp(mag[2]);
      r.out_w = clamp_comp(mag[3]);
      return r;
    end
    root = isqrt_floor(sum);
    len = (sum - root * root > root) ? root + 1 : root;
    if (len == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << (FRAC_BITS + 1)) + len) / (len << 1);
      sv = comp[i] < 0 ? -longint'(q) : longint'(q);
      case (i)
        0: r.out_x = clamp_comp(sv);
        1: r.out_y = clamp_comp(sv);
        2: r.out_z = clamp_comp(sv);
        default: r.out_w = clamp_comp(sv);
      endcase
    end
    r.vec_length = len[24:0];
    return r;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    vna_out_t exp_r;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(predict_vector(in_data));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          if (exp_r !== out_data) begin
            if (fail_count < 10)
              $display("Mismatch: x %h/%h y %h/%h z %h/%h w %h/%h len %h/%h zero %b/%b",
                       exp_r.out_x, out_data.out_x, exp_r.out_y, out_data.out_y,
                       exp_r.out_z, out_data.out_z, exp_r.out_w, out_data.out_w,
                       exp_r.vec_length, out_data.vec_length,
                       exp_r.zero_length, out_data.zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ sim/vec4_normalize_abs_unit_test.sv @@
// ----------------------------------------------------------------------------
// vec4_normalize_abs_unit_test
// Drives directed and random vectors through the normalise / abs unit with
// random gaps and output stalls, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module vec4_normalize_abs_unit_test;
  import vna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The pipeline is 13 stages deep, so a generous tail covers any straggler.
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int LONG_HOLD = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  vna_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vna_out_t out_data;
  int       fail_count;
  int       pending;
  int       idle_cycles = 0;
  int       recv_wait = 0;
  bit       hold_output = 1'b0;

  always #10 clk = ~clk;

  vec4_normalize_abs_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  vec4_normalize_abs_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Offer one transaction, after a random gap when asked for, and hold it until it is taken.
  // Valid is only lowered when no further vector follows straight away.
  task automatic offer_vector(vna_in_t v, bit random_gap);
    int gap;
    gap = random_gap ? $urandom_range(0, 12) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // A component drawn from the extremes, zero, small or medium ranges, or at random.
  function automatic logic [23:0] pick_comp();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'd0;
      3: return 24'($urandom_range(0, 15) - 8);
      4: return 24'($urandom_range(0, 2 ** 17) - 2 ** 16);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic vna_in_t make_vec(cmd_t cmd, logic [23:0] x, logic [23:0] y,
                                       logic [23:0] z, logic [23:0] w);
    vna_in_t v;
    v.command = cmd;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  // Receiver: after each taken result it draws a random wait before it is ready again,
  // and it holds off entirely while a long hold-off is requested.
  always @(posedge clk) begin
    int wait_draw;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else if (hold_output) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      wait_draw = $urandom_range(0, 12);
      recv_wait <= wait_draw;
      out_ready <= (wait_draw == 0);
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_ready <= (recv_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    cmd_t cmd;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed vectors: the zero vector, extremes of each sign, single axes,
    // the saturating most negative value under abs, and tiny lengths.
    offer_vector(make_vec(CMD_NORMALIZE, 24'd0, 24'd0, 24'd0, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_ABS, 24'd0, 24'd0, 24'd0, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'h800000, 24'h800000, 24'h800000,
                          24'h800000), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                          24'h7fffff), 1'b0);
    offer_vector(make_vec(CMD_ABS, 24'h800000, 24'h7fffff, 24'hffffff, 24'd1),
                 1'b0);
    offer_vector(make_vec(CMD_ABS, 24'h800001, 24'h800000, 24'h800000, 24'h800000),
                 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'h800000, 24'd0, 24'd0, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'd0, 24'h7fffff, 24'd0, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'd0, 24'd0, 24'hffffff, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'd0, 24'd0, 24'd0, 24'd1), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'd1, 24'd1, 24'd1, 24'd1), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'd1, 24'hffffff, 24'd1, 24'hffffff),
                 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'd3, 24'd4, 24'd0, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'h010000, 24'h010000, 24'd0, 24'd0), 1'b0);
    offer_vector(make_vec(CMD_NORMALIZE, 24'h7fffff, 24'h800000, 24'h7fffff,
                          24'h800000), 1'b0);
    offer_vector(make_vec(CMD_ABS, 24'h555555, 24'haaaaaa, 24'h123456, 24'hedcba9),
                 1'b0);

    // Random part. Partway through, the receiver holds off for a long stretch
    // while vectors keep coming, so the pipeline fills and stalls its input.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) begin
        fork
          begin
            hold_output <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_output <= 1'b0;
          end
        join_none
      end
      // Once, the sender pauses until every outstanding result has arrived.
      if (n == 700) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
      end
      cmd = cmd_t'($urandom_range(0, 1));
      offer_vector(make_vec(cmd, pick_comp(), pick_comp(), pick_comp(), pick_comp()),
                   (n % 200) > 40);
    end
    in_valid <= 1'b0;

    while (pending > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
